[hdl/ubh_pkg.sv]
// package: shared types and constants of the uniform bin histogram
`default_nettype none

package ubh_pkg;

    localparam int FIELD_W    = 32;
    localparam int OP_W       = 2;
    localparam int BINS_W     = 7;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_LOWER = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_UPPER = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_WIDTH = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_BINS  = 2'd3;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_RMW_WR,
        S_READOUT,
        S_CLEAR
    } t_state;

    typedef struct packed {
        logic load;
        logic advance;
        logic ram_rd;
        logic ram_inc;
        logic ram_zero;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic match;
        logic at_last;
        logic at_top;
    } t_status;

endpackage

`default_nettype wire

[hdl/ubh_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none

module ubh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire                      i_re,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[hdl/ubh_ctrl.sv]
// controller: sequences sample scan, readout and clear sweeps
`default_nettype none

module ubh_ctrl (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         start,
    input  wire  [ubh_pkg::OP_W-1:0]    i_op,
    input  ubh_pkg::t_status            i_status,
    output ubh_pkg::t_cmd               o_cmd,
    output logic                        busy
);

    ubh_pkg::t_state r_state;
    ubh_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ubh_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        unique case (r_state)
            ubh_pkg::S_INIT, ubh_pkg::S_CLEAR: begin
                o_cmd.ram_zero = 1'b1;
                if (i_status.at_top) begin
                    n_state = ubh_pkg::S_IDLE;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            ubh_pkg::S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    unique case (i_op)
                        ubh_pkg::OP_ADD: begin
                            o_cmd.load = 1'b1;
                            n_state    = ubh_pkg::S_SCAN;
                        end
                        ubh_pkg::OP_READ: begin
                            o_cmd.load = 1'b1;
                            n_state    = ubh_pkg::S_READOUT;
                        end
                        ubh_pkg::OP_CLEAR: begin
                            o_cmd.load = 1'b1;
                            n_state    = ubh_pkg::S_CLEAR;
                        end
                        default: begin
                            n_state = ubh_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            ubh_pkg::S_SCAN: begin
                if (i_status.match) begin
                    o_cmd.ram_rd = 1'b1;
                    n_state      = ubh_pkg::S_RMW_WR;
                end else if (i_status.at_last) begin
                    n_state = ubh_pkg::S_IDLE;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            ubh_pkg::S_RMW_WR: begin
                o_cmd.ram_inc = 1'b1;
                n_state       = ubh_pkg::S_IDLE;
            end
            ubh_pkg::S_READOUT: begin
                o_cmd.ram_rd = 1'b1;
                o_cmd.emit   = 1'b1;
                if (i_status.at_last) begin
                    n_state = ubh_pkg::S_IDLE;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            default: begin
                n_state = ubh_pkg::S_INIT;
            end
        endcase
    end

endmodule

`default_nettype wire

[hdl/ubh_datapath.sv]
// datapath: config registers, edge stepping, bin compare, count ram, result beat
`default_nettype none

module ubh_datapath #(
    parameter int MAX_BINS   = 64,
    parameter int VALUE_BITS = 32,
    parameter int COUNT_BITS = 32
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire  [ubh_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire  [ubh_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire  [ubh_pkg::FIELD_W-1:0]       i_sample_value,
    input  ubh_pkg::t_cmd                     i_cmd,
    output ubh_pkg::t_status                  o_status,
    output logic                              o_result_valid,
    output logic [ubh_pkg::FIELD_W-1:0]       o_bin_center,
    output logic [ubh_pkg::FIELD_W-1:0]       o_hits,
    output logic                              o_last_bin
);

    localparam int IDX_W = $clog2(MAX_BINS);
    localparam int NW    = (IDX_W + 1 > ubh_pkg::BINS_W) ? IDX_W + 1 : ubh_pkg::BINS_W;

    logic [VALUE_BITS-1:0]      r_lower;
    logic [VALUE_BITS-1:0]      r_upper;
    logic [VALUE_BITS-1:0]      r_width;
    logic [ubh_pkg::BINS_W-1:0] r_bins;

    logic [VALUE_BITS-1:0] r_sample;
    logic [VALUE_BITS-1:0] r_lo;
    logic [IDX_W-1:0]      r_idx;

    logic [VALUE_BITS-1:0] r_center;
    logic                  r_last;
    logic                  r_valid;

    logic [NW-1:0]         bins_ext;
    logic [IDX_W-1:0]      last_idx;
    logic [VALUE_BITS:0]   step_sum;
    logic [VALUE_BITS-1:0] hi;
    logic [VALUE_BITS-1:0] center;
    logic [COUNT_BITS-1:0] ram_rdata;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic                  ram_we;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= '0;
            r_upper <= VALUE_BITS'(32'hFFFF_FFFF);
            r_width <= VALUE_BITS'(1);
            r_bins  <= ubh_pkg::BINS_W'(10);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                ubh_pkg::CFG_LOWER: r_lower <= VALUE_BITS'(i_cfg_data);
                ubh_pkg::CFG_UPPER: r_upper <= VALUE_BITS'(i_cfg_data);
                ubh_pkg::CFG_WIDTH: r_width <= VALUE_BITS'(i_cfg_data);
                ubh_pkg::CFG_BINS:  r_bins  <= i_cfg_data[ubh_pkg::BINS_W-1:0];
            endcase
        end
    end

    // clamp bins in use to 1..MAX_BINS
    always_comb begin
        bins_ext = NW'(r_bins);
        if (bins_ext == '0) begin
            last_idx = '0;
        end else if (bins_ext > NW'(MAX_BINS)) begin
            last_idx = IDX_W'(MAX_BINS - 1);
        end else begin
            last_idx = IDX_W'(bins_ext - NW'(1));
        end
    end

    // saturating edge step, last edge is the upper edge
    always_comb begin
        step_sum = {1'b0, r_lo} + {1'b0, r_width};
        if (r_idx == last_idx) begin
            hi = r_upper;
        end else if (step_sum[VALUE_BITS]) begin
            hi = '1;
        end else begin
            hi = step_sum[VALUE_BITS-1:0];
        end
        center = (r_lo >> 1) + (hi >> 1) + VALUE_BITS'(r_lo[0] & hi[0]);
    end

    assign o_status.match   = (r_lo < r_sample) && (r_sample < hi);
    assign o_status.at_last = (r_idx == last_idx);
    assign o_status.at_top  = (r_idx == IDX_W'(MAX_BINS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.load) begin
            r_idx <= '0;
        end else if (i_cmd.advance) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= VALUE_BITS'(i_sample_value);
            r_lo     <= r_lower;
        end else if (i_cmd.advance) begin
            r_lo <= hi;
        end
    end

    assign ram_we    = i_cmd.ram_inc | i_cmd.ram_zero;
    assign ram_wdata = i_cmd.ram_zero ? '0
                     : ((&ram_rdata) ? ram_rdata : ram_rdata + COUNT_BITS'(1));

    ubh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (MAX_BINS)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.ram_rd),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // result beat lines up with the registered count read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_center <= center;
            r_last   <= o_status.at_last;
        end
    end

    assign o_result_valid = r_valid;
    assign o_bin_center   = ubh_pkg::FIELD_W'(r_center);
    assign o_hits         = ubh_pkg::FIELD_W'(ram_rdata);
    assign o_last_bin     = r_last;

endmodule

`default_nettype wire

[hdl/uniform_bin_histogram.sv]
// uniform bin histogram top level: controller plus datapath
// add: one bin compared per cycle over the n bins in use, plus a
//   read-modify-write of the count ram when a bin matches
// readout: one result beat per cycle for each of the n bins in use,
//   the last beat arriving in the same cycle that busy drops
// clear: one count ram entry zeroed per cycle after the accept, over all MAX_BINS entries
// reset: synchronous; a clearing pass over all MAX_BINS entries follows with busy high
// results are strobed for one cycle and cannot be stalled
`default_nettype none

module uniform_bin_histogram #(
    parameter int MAX_BINS   = 64,
    parameter int VALUE_BITS = 32,
    parameter int COUNT_BITS = 32
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             start,
    output logic                            busy,
    input  wire  [ubh_pkg::OP_W-1:0]        i_op,
    input  wire  [ubh_pkg::FIELD_W-1:0]     i_sample_value,
    output logic                            o_result_valid,
    output logic [ubh_pkg::FIELD_W-1:0]     o_bin_center,
    output logic [ubh_pkg::FIELD_W-1:0]     o_hits,
    output logic                            o_last_bin,
    input  wire                             i_cfg_we,
    input  wire  [ubh_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire  [ubh_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    ubh_pkg::t_cmd    cmd;
    ubh_pkg::t_status status;

    ubh_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_op     (i_op),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    ubh_datapath #(
        .MAX_BINS   (MAX_BINS),
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .i_sample_value (i_sample_value),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_result_valid (o_result_valid),
        .o_bin_center   (o_bin_center),
        .o_hits         (o_hits),
        .o_last_bin     (o_last_bin)
    );

endmodule

`default_nettype wire

[tb/sv/tb_uniform_bin_histogram.sv]
// testbench for the uniform bin histogram: directed and random beats against a scoreboard
`timescale 1ns / 1ps

module tb_uniform_bin_histogram;

    localparam int MAX_BINS = 64;
    localparam int CYCLE_LIMIT = 300000;
    localparam logic [ubh_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [ubh_pkg::FIELD_W-1:0] VALUE_TOP = '1;

    typedef struct packed {
        logic [ubh_pkg::FIELD_W-1:0] center;
        logic [ubh_pkg::FIELD_W-1:0] hits;
        logic                        last_bin;
    } t_bin_beat;

    class t_bin_tally_model;
        logic [ubh_pkg::FIELD_W-1:0] lo_edge;
        logic [ubh_pkg::FIELD_W-1:0] hi_edge;
        logic [ubh_pkg::FIELD_W-1:0] bin_step;
        logic [ubh_pkg::BINS_W-1:0]  bins_cfg;
        logic [ubh_pkg::FIELD_W-1:0] tally [MAX_BINS];
        logic [ubh_pkg::FIELD_W-1:0] edge_at [MAX_BINS+1];
        int                          n_active;
        t_bin_beat                   pending[$];
        int                          errors;

        function new();
            lo_edge  = '0;
            hi_edge  = VALUE_TOP;
            bin_step = 32'd1;
            bins_cfg = 7'd10;
            errors   = 0;
            foreach (tally[i]) tally[i] = '0;
            refresh_edges();
        endfunction

        function void refresh_edges();
            n_active = bins_cfg;
            if (n_active < 1) n_active = 1;
            if (n_active > MAX_BINS) n_active = MAX_BINS;
            edge_at[0] = lo_edge;
            for (int i = 1; i < n_active; i++) begin
                if (bin_step >= VALUE_TOP - edge_at[i-1]) begin
                    edge_at[i] = VALUE_TOP;
                end else begin
                    edge_at[i] = edge_at[i-1] + bin_step;
                end
            end
            edge_at[n_active] = hi_edge;
        endfunction

        function void write_reg(logic [ubh_pkg::CFG_ADDR_W-1:0] idx,
                                logic [ubh_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                ubh_pkg::CFG_LOWER: lo_edge  = data;
                ubh_pkg::CFG_UPPER: hi_edge  = data;
                ubh_pkg::CFG_WIDTH: bin_step = data;
                ubh_pkg::CFG_BINS:  bins_cfg = data[ubh_pkg::BINS_W-1:0];
                default: ;
            endcase
            refresh_edges();
        endfunction

        function void take_item(logic [ubh_pkg::OP_W-1:0] op, logic [ubh_pkg::FIELD_W-1:0] x);
            logic                        found;
            logic [ubh_pkg::FIELD_W-1:0] a;
            logic [ubh_pkg::FIELD_W-1:0] b;
            t_bin_beat                   beat;
            found = 1'b0;
            case (op)
                ubh_pkg::OP_ADD: begin
                    for (int i = 0; i < n_active; i++) begin
                        if (!found && edge_at[i] < x && x < edge_at[i+1]) begin
                            found = 1'b1;
                            if (tally[i] != VALUE_TOP) tally[i] = tally[i] + 1'b1;
                        end
                    end
                end
                ubh_pkg::OP_READ: begin
                    for (int i = 0; i < n_active; i++) begin
                        a = edge_at[i];
                        b = edge_at[i+1];
                        beat.center   = (a >> 1) + (b >> 1) + {31'd0, a[0] & b[0]};
                        beat.hits     = tally[i];
                        beat.last_bin = (i == n_active - 1);
                        pending.push_back(beat);
                    end
                end
                ubh_pkg::OP_CLEAR: begin
                    foreach (tally[i]) tally[i] = '0;
                end
                default: ;
            endcase
        endfunction

        task flag(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_bin(logic [ubh_pkg::FIELD_W-1:0] center, logic [ubh_pkg::FIELD_W-1:0] hits,
                       logic last_bin);
            t_bin_beat want;
            if (pending.size() == 0) begin
                flag($sformatf("unexpected beat center %h hits %h", center, hits));
            end else begin
                want = pending.pop_front();
                if (center !== want.center)
                    flag($sformatf("bin_center got %h want %h", center, want.center));
                if (hits !== want.hits)
                    flag($sformatf("hits got %h want %h", hits, want.hits));
                if (last_bin !== want.last_bin)
                    flag($sformatf("last_bin got %b want %b", last_bin, want.last_bin));
            end
        endtask
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    logic [ubh_pkg::OP_W-1:0]       i_op;
    logic [ubh_pkg::FIELD_W-1:0]    i_sample_value;
    logic                           o_result_valid;
    logic [ubh_pkg::FIELD_W-1:0]    o_bin_center;
    logic [ubh_pkg::FIELD_W-1:0]    o_hits;
    logic                           o_last_bin;
    logic                           i_cfg_we;
    logic [ubh_pkg::CFG_ADDR_W-1:0] i_cfg_addr;
    logic [ubh_pkg::CFG_DATA_W-1:0] i_cfg_data;

    t_bin_tally_model model;
    logic             burst;
    int               cycles;

    uniform_bin_histogram dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_sample_value (i_sample_value),
        .o_result_valid (o_result_valid),
        .o_bin_center   (o_bin_center),
        .o_hits         (o_hits),
        .o_last_bin     (o_last_bin),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial cycles = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            model.check_bin(o_bin_center, o_hits, o_last_bin);
        end
    end

    task automatic send_item(logic [ubh_pkg::OP_W-1:0] op, logic [ubh_pkg::FIELD_W-1:0] x);
        int gap;
        if ($urandom_range(0, 7) == 0) burst = !burst;
        gap = burst ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_op           <= op;
        i_sample_value <= x;
        do @(posedge i_clk); while (busy);
        model.take_item(op, x);
    endtask

    // hold off until all bins are back and the block has gone idle
    task automatic settle();
        start <= 1'b0;
        while (model.pending.size() != 0) @(posedge i_clk);
        repeat (MAX_BINS + 8) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [ubh_pkg::CFG_ADDR_W-1:0] idx,
                             logic [ubh_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        model.write_reg(idx, data);
    endtask

    task automatic configure(logic [31:0] lo, logic [31:0] hi, logic [31:0] w, logic [31:0] n);
        settle();
        write_reg(ubh_pkg::CFG_LOWER, lo);
        write_reg(ubh_pkg::CFG_UPPER, hi);
        write_reg(ubh_pkg::CFG_WIDTH, w);
        write_reg(ubh_pkg::CFG_BINS, n);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [ubh_pkg::FIELD_W-1:0] pick_sample();
        int unsigned r;
        r = $urandom_range(0, 3);
        if (r == 0) return $urandom;
        if (r == 1) return model.edge_at[$urandom_range(0, model.n_active)];
        if (model.hi_edge > model.lo_edge)
            return model.lo_edge + $urandom_range(0, model.hi_edge - model.lo_edge);
        return $urandom;
    endfunction

    task automatic random_items(int count);
        int unsigned r;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 72) begin
                send_item(ubh_pkg::OP_ADD, pick_sample());
            end else if (r < 84) begin
                send_item(ubh_pkg::OP_READ, $urandom);
            end else if (r < 94) begin
                send_item(ubh_pkg::OP_CLEAR, $urandom);
            end else begin
                send_item(OP_UNUSED, $urandom);
            end
        end
        send_item(ubh_pkg::OP_READ, $urandom);
    endtask

    initial begin
        model = new();
        burst = 1'b0;
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_op           <= ubh_pkg::OP_ADD;
        i_sample_value <= '0;
        i_cfg_we       <= 1'b0;
        i_cfg_addr     <= ubh_pkg::CFG_LOWER;
        i_cfg_data     <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset configuration: ten unit bins, last one runs to the top
        send_item(ubh_pkg::OP_ADD, 32'd0);
        send_item(ubh_pkg::OP_ADD, 32'd5);
        send_item(ubh_pkg::OP_ADD, 32'd10);
        send_item(ubh_pkg::OP_ADD, 32'h8000_0000);
        send_item(ubh_pkg::OP_ADD, VALUE_TOP);
        send_item(OP_UNUSED, VALUE_TOP);
        send_item(ubh_pkg::OP_READ, 32'd0);
        send_item(ubh_pkg::OP_CLEAR, 32'd0);
        send_item(ubh_pkg::OP_READ, VALUE_TOP);
        random_items(10);

        configure(32'd100, 32'd1000, 32'd90, 32'd10);
        send_item(ubh_pkg::OP_ADD, 32'd99);
        send_item(ubh_pkg::OP_ADD, 32'd100);
        send_item(ubh_pkg::OP_ADD, 32'd101);
        send_item(ubh_pkg::OP_ADD, 32'd189);
        send_item(ubh_pkg::OP_ADD, 32'd190);
        send_item(ubh_pkg::OP_ADD, 32'd999);
        send_item(ubh_pkg::OP_ADD, 32'd1000);
        send_item(ubh_pkg::OP_READ, 32'd0);
        random_items(12);

        // edges past the top saturate
        configure(32'd0, VALUE_TOP, 32'h0800_0000, 32'd64);
        send_item(ubh_pkg::OP_ADD, 32'h8000_0001);
        send_item(ubh_pkg::OP_READ, 32'd0);
        random_items(12);

        // zero width: only the last bin can count
        configure(32'd50, 32'd60, 32'd0, 32'd4);
        send_item(ubh_pkg::OP_ADD, 32'd55);
        send_item(ubh_pkg::OP_ADD, 32'd50);
        send_item(ubh_pkg::OP_READ, 32'd0);
        random_items(10);

        // bin count of zero acts as one, upper below lower
        configure(32'hFFFF_FFF0, 32'd10, 32'd3, 32'hFFFF_FF80);
        random_items(10);

        // bin count above the maximum, upper below inner edges
        configure(32'd1000, 32'd500, 32'd7, 32'd100);
        random_items(10);

        configure(VALUE_TOP, VALUE_TOP, VALUE_TOP, 32'd127);
        random_items(8);

        configure(32'd0, 32'd7, 32'd1, 32'd1);
        random_items(10);

        settle();
        if (model.pending.size() != 0)
            model.flag($sformatf("%0d beats never arrived", model.pending.size()));
        if (model.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
